// File: hw/rtl/gpio_register_block_defines.svh
// Assertion macros shared by the GPIO register block RTL.
// Modules that use them must have clk and arst_n in scope.
`ifndef GPIO_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_REGISTER_BLOCK_DEFINES_SVH
`ifndef SYNTHESIS
`define GRB_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("gpio_register_block: invariant violated");
`define GRB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gpio_register_block: next-cycle check failed");
`else
`define GRB_ASSERT(lbl, expr)
`define GRB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/gpiorb_pkg.sv
// Package for the GPIO register block: sizes, register offsets, access codes,
// the transaction and result structs, and the function-select mask helper.
// No dependencies.
package gpiorb_pkg;

	localparam int NUM_PINS      = 54;
	localparam int FSEL_WORDS    = 6;
	localparam int FSEL_PER_WORD = 10;
	localparam int FSEL_BITS     = 3;
	localparam int FSEL_USED_W   = FSEL_PER_WORD * FSEL_BITS;
	localparam int WORD_W        = 32;
	localparam int SLOT_W        = 2 * WORD_W;
	localparam int LEVEL_W       = 54;
	localparam int OFS_W         = 6;
	localparam int PIN_W         = 6;
	localparam int PULL_W        = 2;

	localparam logic [SLOT_W-1:0] PIN_MASK = (SLOT_W'(1) << NUM_PINS) - SLOT_W'(1);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [OFS_W-1:0] OFS_FSEL_FIRST = 6'd0;
	localparam logic [OFS_W-1:0] OFS_FSEL_LAST  = 6'd5;
	localparam logic [OFS_W-1:0] OFS_SET0       = 6'd7;
	localparam logic [OFS_W-1:0] OFS_SET1       = 6'd8;
	localparam logic [OFS_W-1:0] OFS_CLR0       = 6'd10;
	localparam logic [OFS_W-1:0] OFS_CLR1       = 6'd11;
	localparam logic [OFS_W-1:0] OFS_PUD        = 6'd37;
	localparam logic [OFS_W-1:0] OFS_PUDCLK0    = 6'd38;
	localparam logic [OFS_W-1:0] OFS_PUDCLK1    = 6'd39;

	typedef struct packed {
		logic              opcode;
		logic [OFS_W-1:0]  word_offset;
		logic [WORD_W-1:0] write_data;
		logic [PIN_W-1:0]  probe_pin;
	} access_t;

	typedef struct packed {
		logic [WORD_W-1:0]  read_data;
		logic               bad_offset;
		logic [LEVEL_W-1:0] output_levels;
		logic [PULL_W-1:0]  probe_pull;
	} result_t;

	// Bits of a function-select word that belong to pins that exist.
	function automatic logic [FSEL_USED_W-1:0] fsel_mask(input int word);
		logic [FSEL_USED_W-1:0] m;
		m = '0;
		for (int k = 0; k < FSEL_PER_WORD; k++) begin
			if (word * FSEL_PER_WORD + k < NUM_PINS) begin
				m[k*FSEL_BITS +: FSEL_BITS] = '1;
			end
		end
		return m;
	endfunction

endpackage

// File: hw/rtl/gpiorb_in_reg.sv
// Input register of the GPIO register block: captures one bus transaction.
// Depends on gpiorb_pkg.
module gpiorb_in_reg import gpiorb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  access_t in_acc,
	input  logic    advance,
	output logic    valid_s1,
	output access_t acc_s1
);

	// The held transaction leaves whenever the result stage takes it.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			acc_s1 <= in_acc;
		end
	end

endmodule

// File: hw/rtl/gpiorb_regfile.sv
// Register state of the GPIO register block and the single-pass access logic.
// Depends on gpiorb_pkg and gpio_register_block_defines.svh.
`include "gpio_register_block_defines.svh"
module gpiorb_regfile import gpiorb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  access_t acc,
	output result_t res
);

	logic [FSEL_USED_W-1:0] fsel_q [FSEL_WORDS];
	logic [SLOT_W-1:0]      latch_q;
	logic [PULL_W-1:0]      pud_q;
	logic [WORD_W-1:0]      pclk0_q;
	logic [WORD_W-1:0]      pclk1_q;
	logic [PULL_W-1:0]      pull_q [NUM_PINS];

	logic [SLOT_W-1:0]      latch_d;
	logic [PULL_W-1:0]      pud_d;
	logic [WORD_W-1:0]      pclk0_d;
	logic [WORD_W-1:0]      pclk1_d;
	logic [SLOT_W-1:0]      pclk_all;
	logic [PULL_W-1:0]      pull_d [NUM_PINS];
	logic                   do_latch;
	logic                   is_write;
	logic                   is_fsel;
	logic [SLOT_W-1:0]      low_bank;
	logic [SLOT_W-1:0]      high_bank;
	logic [WORD_W-1:0]      rd_data;
	logic                   bad_ofs;
	logic [PULL_W-1:0]      probe_pull;

	assign is_write  = (acc.opcode == OP_WRITE);
	assign is_fsel   = (acc.word_offset inside {[OFS_FSEL_FIRST:OFS_FSEL_LAST]});
	assign low_bank  = {{WORD_W{1'b0}}, acc.write_data} & PIN_MASK;
	assign high_bank = {acc.write_data, {WORD_W{1'b0}}} & PIN_MASK;

	always_comb begin
		latch_d  = latch_q;
		pud_d    = pud_q;
		pclk0_d  = pclk0_q;
		pclk1_d  = pclk1_q;
		do_latch = 1'b0;
		rd_data  = '0;
		bad_ofs  = 1'b0;
		if (is_fsel) begin
			for (int w = 0; w < FSEL_WORDS; w++) begin
				if (acc.word_offset == OFS_W'(w) && !is_write) begin
					rd_data = WORD_W'(fsel_q[w]);
				end
			end
		end else if (acc.word_offset == OFS_SET0) begin
			if (is_write) latch_d = latch_q | low_bank;
		end else if (acc.word_offset == OFS_SET1) begin
			if (is_write) latch_d = latch_q | high_bank;
		end else if (acc.word_offset == OFS_CLR0) begin
			if (is_write) latch_d = latch_q & ~low_bank;
		end else if (acc.word_offset == OFS_CLR1) begin
			if (is_write) latch_d = latch_q & ~high_bank;
		end else if (acc.word_offset == OFS_PUD) begin
			if (is_write) begin
				pud_d    = acc.write_data[PULL_W-1:0];
				do_latch = 1'b1;
			end else begin
				rd_data = WORD_W'(pud_q);
			end
		end else if (acc.word_offset == OFS_PUDCLK0) begin
			if (is_write) begin
				pclk0_d  = low_bank[WORD_W-1:0];
				do_latch = 1'b1;
			end else begin
				rd_data = pclk0_q;
			end
		end else if (acc.word_offset == OFS_PUDCLK1) begin
			if (is_write) begin
				pclk1_d  = high_bank[SLOT_W-1:WORD_W];
				do_latch = 1'b1;
			end else begin
				rd_data = pclk1_q;
			end
		end else begin
			bad_ofs = 1'b1;
		end
	end

	// Pins whose pull-clock bit is held take the pull code on a PUD or PUDCLK write.
	assign pclk_all = {pclk1_d, pclk0_d};

	always_comb begin
		probe_pull = '0;
		for (int p = 0; p < NUM_PINS; p++) begin
			pull_d[p] = (do_latch && pclk_all[p]) ? pud_d : pull_q[p];
			if (acc.probe_pin == PIN_W'(p)) begin
				probe_pull = pull_d[p];
			end
		end
	end

	assign res = '{read_data: rd_data, bad_offset: bad_ofs,
		output_levels: latch_d[LEVEL_W-1:0], probe_pull: probe_pull};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < FSEL_WORDS; w++) begin
				fsel_q[w] <= '0;
			end
			for (int p = 0; p < NUM_PINS; p++) begin
				pull_q[p] <= '0;
			end
			latch_q <= '0;
			pud_q   <= '0;
			pclk0_q <= '0;
			pclk1_q <= '0;
		end else if (en) begin
			for (int w = 0; w < FSEL_WORDS; w++) begin
				if (is_write && acc.word_offset == OFS_W'(w)) begin
					fsel_q[w] <= acc.write_data[FSEL_USED_W-1:0] & fsel_mask(w);
				end
			end
			for (int p = 0; p < NUM_PINS; p++) begin
				pull_q[p] <= pull_d[p];
			end
			latch_q <= latch_d;
			pud_q   <= pud_d;
			pclk0_q <= pclk0_d;
			pclk1_q <= pclk1_d;
		end
	end

	`GRB_ASSERT(a_latch_no_missing_pins, (latch_q & ~PIN_MASK) == '0)
	`GRB_ASSERT(a_pclk_no_missing_pins, ({pclk1_q, pclk0_q} & ~PIN_MASK) == '0)
	`GRB_ASSERT(a_bad_reads_zero, !en || !res.bad_offset || res.read_data == '0)
	`GRB_ASSERT_NEXT(a_clr_all_low_bank,
		en && is_write && acc.word_offset == OFS_CLR0 && acc.write_data == '1,
		latch_q[WORD_W-1:0] == '0)
	`GRB_ASSERT_NEXT(a_pud_write_kept,
		en && is_write && acc.word_offset == OFS_PUD,
		pud_q == $past(acc.write_data[PULL_W-1:0]))

endmodule

// File: hw/rtl/gpiorb_out_reg.sv
// Result register of the GPIO register block: holds one result until taken.
// Depends on gpiorb_pkg.
module gpiorb_out_reg import gpiorb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t res,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_s2
);

	// A new result may enter when the register is empty or being emptied.
	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

endmodule

// File: hw/rtl/gpio_register_block.sv
// GPIO register block: a register bank with one bus access per transaction.
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one register
//   access per transaction: s_tuser is the access kind (0 read, 1 write) and
//   s_tdata carries the word offset, the write data and a probe pin.
//   The master channel (m_tvalid/m_tready/m_tdata) returns exactly one result
//   per access: read data, a bad-offset flag, the output latch of all pins
//   after the access and the latched pull code of the probed pin.
//   From acceptance to m_tvalid the access sits in the input register, then the
//   decode and state update load the result register.
//   Throughput is one transaction per cycle while m_tready is high; the
//   whole access is a parallel decode and bit update, so nothing in the datapath iterates.
//   When m_tready is low the result register holds its contents, the input
//   register fills, and s_tready then drops until the result is taken; the
//   register state only changes when an access moves into the result register.
//   Reset (arst_n low) clears both valid flags, all function selects, the
//   output latch, the pull code, the pull-clock words and every pin's pull state.
// Depends on gpiorb_pkg, gpiorb_in_reg, gpiorb_regfile and gpiorb_out_reg.
module gpio_register_block import gpiorb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // word_offset[5:0], write_data[37:6], probe_pin[43:38], zero
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata   // read_data[31:0], bad_offset[32], output_levels[86:33],
	                              // probe_pull[88:87], zero
);

	access_t in_acc;
	access_t acc_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s1;
	logic    advance;

	assign in_acc.opcode      = s_tuser;
	assign in_acc.word_offset = s_tdata[5:0];
	assign in_acc.write_data  = s_tdata[37:6];
	assign in_acc.probe_pin   = s_tdata[43:38];

	gpiorb_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_acc   (in_acc),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.acc_s1   (acc_s1)
	);

	gpiorb_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.acc    (acc_s1),
		.res    (res)
	);

	gpiorb_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_s2    (res_s2)
	);

	assign m_tdata = {7'b0, res_s2.probe_pull, res_s2.output_levels, res_s2.bad_offset,
		res_s2.read_data};

endmodule

// File: tb/tb_gpio_register_block.sv
// Self-checking testbench for gpio_register_block: a directed table, then random register
// accesses, with each result compared against a typed-in value or a behavioral predictor of the register bank.
// Depends on gpiorb_pkg and the gpio_register_block RTL.
module tb_gpio_register_block;
	import gpiorb_pkg::*;

	typedef struct {
		access_t acc;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // word_offset[5:0], write_data[37:6], probe_pin[43:38], zero
	logic        s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;  // read_data[31:0], bad_offset[32], output_levels[86:33],
	                       // probe_pull[88:87], zero

	// Access currently offered on the slave side, with its typed-in result if it has one.
	access_t cur_acc;
	bit      cur_typed;
	result_t cur_want;
	bit      quiet;
	int      errors;

	// Predicted register state.
	logic [FSEL_BITS-1:0] fsel_q [NUM_PINS];
	logic [LEVEL_W-1:0]   levels_q;
	logic [PULL_W-1:0]    pull_code_q;
	logic [WORD_W-1:0]    pull_clk_q [2];
	logic [PULL_W-1:0]    pin_pull_q [NUM_PINS];

	result_t   pending_results [$];
	stim_row_t directed [$];

	gpio_register_block dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	assign s_tdata = {4'b0, cur_acc.probe_pin, cur_acc.write_data, cur_acc.word_offset};
	assign s_tuser = cur_acc.opcode;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic access_t make_access(input logic op, input logic [OFS_W-1:0] ofs,
			input logic [WORD_W-1:0] data, input logic [PIN_W-1:0] probe);
		access_t a;
		a.opcode      = op;
		a.word_offset = ofs;
		a.write_data  = data;
		a.probe_pin   = probe;
		return a;
	endfunction

	function automatic result_t make_result(input logic [WORD_W-1:0] rd, input logic bad,
			input logic [LEVEL_W-1:0] levels, input logic [PULL_W-1:0] pull);
		result_t r;
		r.read_data     = rd;
		r.bad_offset    = bad;
		r.output_levels = levels;
		r.probe_pull    = pull;
		return r;
	endfunction

	// Every pin whose pull-clock bit is held takes the current pull code.
	function automatic void latch_pin_pulls();
		for (int p = 0; p < NUM_PINS; p++) begin
			if (pull_clk_q[p / WORD_W][p % WORD_W]) begin
				pin_pull_q[p] = pull_code_q;
			end
		end
	endfunction

	function automatic result_t apply_access(input access_t a);
		result_t           r;
		logic [WORD_W-1:0] bank_pins;
		logic [SLOT_W-1:0] wide;
		int                bank;
		int                pin;
		r = '0;
		if (a.word_offset <= OFS_FSEL_LAST) begin
			for (int k = 0; k < FSEL_PER_WORD; k++) begin
				pin = a.word_offset * FSEL_PER_WORD + k;
				if (pin < NUM_PINS) begin
					if (a.opcode == OP_WRITE) begin
						fsel_q[pin] = a.write_data[k*FSEL_BITS +: FSEL_BITS];
					end else begin
						r.read_data[k*FSEL_BITS +: FSEL_BITS] = fsel_q[pin];
					end
				end
			end
		end else if (a.word_offset == OFS_SET0 || a.word_offset == OFS_SET1
				|| a.word_offset == OFS_CLR0 || a.word_offset == OFS_CLR1) begin
			bank = (a.word_offset == OFS_SET1 || a.word_offset == OFS_CLR1) ? 1 : 0;
			bank_pins = PIN_MASK[bank*WORD_W +: WORD_W];
			wide = SLOT_W'(a.write_data & bank_pins) << (bank * WORD_W);
			if (a.opcode == OP_WRITE) begin
				if (a.word_offset == OFS_SET0 || a.word_offset == OFS_SET1) begin
					levels_q = levels_q | wide[LEVEL_W-1:0];
				end else begin
					levels_q = levels_q & ~wide[LEVEL_W-1:0];
				end
			end
		end else if (a.word_offset == OFS_PUD) begin
			if (a.opcode == OP_WRITE) begin
				pull_code_q = a.write_data[PULL_W-1:0];
				latch_pin_pulls();
			end else begin
				r.read_data = WORD_W'(pull_code_q);
			end
		end else if (a.word_offset == OFS_PUDCLK0 || a.word_offset == OFS_PUDCLK1) begin
			bank = (a.word_offset == OFS_PUDCLK1) ? 1 : 0;
			bank_pins = PIN_MASK[bank*WORD_W +: WORD_W];
			if (a.opcode == OP_WRITE) begin
				pull_clk_q[bank] = a.write_data & bank_pins;
				latch_pin_pulls();
			end else begin
				r.read_data = pull_clk_q[bank];
			end
		end else begin
			r.bad_offset = 1'b1;
		end
		r.output_levels = levels_q;
		r.probe_pull = (a.probe_pin < NUM_PINS) ? pin_pull_q[a.probe_pin] : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s: got %h, expected %h", field, got, want);
		errors++;
	endtask

	// Result checker and predictor feed, both on the rising edge.
	always @(posedge clk) begin
		result_t r;
		result_t predicted;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[63:0], 64'h0);
				end else begin
					r = pending_results.pop_front();
					if (m_tdata[31:0] !== r.read_data)
						report_mismatch("read_data", 64'(m_tdata[31:0]),
							64'(r.read_data));
					if (m_tdata[32] !== r.bad_offset)
						report_mismatch("bad_offset", 64'(m_tdata[32]),
							64'(r.bad_offset));
					if (m_tdata[86:33] !== r.output_levels)
						report_mismatch("output_levels", 64'(m_tdata[86:33]),
							64'(r.output_levels));
					if (m_tdata[88:87] !== r.probe_pull)
						report_mismatch("probe_pull", 64'(m_tdata[88:87]),
							64'(r.probe_pull));
				end
			end
			if (s_tvalid && s_tready) begin
				predicted = apply_access(cur_acc);
				pending_results.push_back(cur_typed ? cur_want : predicted);
			end
		end
	end

	// Offer one access, sometimes with a random idle burst first unless quiet is set, and return
	// at the falling edge after it has been accepted.
	task automatic send_access(input access_t a, input bit typed, input result_t want);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_acc = a;
		cur_typed = typed;
		cur_want = want;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Receiver: random stall bursts, calm stretches, and no stalls once quiet is set.
	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm_left > 0) begin
				calm_left--;
			end else if (!quiet && stall_left == 0) begin
				if ($urandom_range(0, 99) == 0) begin
					calm_left = $urandom_range(50, 200);
				end else if ($urandom_range(0, 9) == 0) begin
					stall_left = $urandom_range(1, 16);
				end
			end
			if (stall_left > 0 && !quiet) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		access_t           a;
		logic [WORD_W-1:0] d;
		logic [PIN_W-1:0]  pr;
		logic [OFS_W-1:0]  ofs;
		int                sent;
		int                pick;
		bit                paused;
		errors = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		cur_acc = '0;
		cur_typed = 1'b0;
		cur_want = '0;
		for (int p = 0; p < NUM_PINS; p++) begin
			fsel_q[p] = '0;
			pin_pull_q[p] = '0;
		end
		levels_q = '0;
		pull_code_q = '0;
		pull_clk_q[0] = '0;
		pull_clk_q[1] = '0;

		// Expected values are typed in where they follow directly from reset and the extremes.
		directed.push_back('{make_access(OP_READ, OFS_FSEL_FIRST, 32'h0, 6'd0), 1'b1,
			make_result(32'h0, 1'b0, 54'h0, 2'd0)});
		directed.push_back('{make_access(OP_WRITE, OFS_SET0, 32'hFFFF_FFFF, 6'd1), 1'b1,
			make_result(32'h0, 1'b0, 54'h0_FFFF_FFFF, 2'd0)});
		directed.push_back('{make_access(OP_WRITE, OFS_SET1, 32'hFFFF_FFFF, 6'd63), 1'b1,
			make_result(32'h0, 1'b0, 54'h3F_FFFF_FFFF_FFFF, 2'd0)});
		directed.push_back('{make_access(OP_READ, OFS_SET0, 32'hFFFF_FFFF, 6'd53), 1'b1,
			make_result(32'h0, 1'b0, 54'h3F_FFFF_FFFF_FFFF, 2'd0)});
		directed.push_back('{make_access(OP_WRITE, OFS_CLR1, 32'hFFFF_FFFF, 6'd0), 1'b1,
			make_result(32'h0, 1'b0, 54'h0_FFFF_FFFF, 2'd0)});
		directed.push_back('{make_access(OP_WRITE, OFS_CLR0, 32'h0000_0001, 6'd0), 1'b1,
			make_result(32'h0, 1'b0, 54'h0_FFFF_FFFE, 2'd0)});
		directed.push_back('{make_access(OP_READ, 6'd63, 32'h0, 6'd0), 1'b1,
			make_result(32'h0, 1'b1, 54'h0_FFFF_FFFE, 2'd0)});
		directed.push_back('{make_access(OP_WRITE, 6'd6, 32'hFFFF_FFFF, 6'd0), 1'b1,
			make_result(32'h0, 1'b1, 54'h0_FFFF_FFFE, 2'd0)});
		directed.push_back('{make_access(OP_READ, OFS_CLR1, 32'h0, 6'd0), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_FSEL_FIRST, 32'hFFFF_FFFF, 6'd0), 1'b0,
			'0});
		directed.push_back('{make_access(OP_READ, OFS_FSEL_FIRST, 32'h0, 6'd0), 1'b1,
			make_result(32'h3FFF_FFFF, 1'b0, 54'h0_FFFF_FFFE, 2'd0)});
		directed.push_back('{make_access(OP_WRITE, OFS_FSEL_LAST, 32'hFFFF_FFFF, 6'd0), 1'b0,
			'0});
		directed.push_back('{make_access(OP_READ, OFS_FSEL_LAST, 32'h0, 6'd0), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUD, 32'hFFFF_FFFE, 6'd0), 1'b0, '0});
		directed.push_back('{make_access(OP_READ, OFS_PUD, 32'h0, 6'd0), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUDCLK1, 32'hFFFF_FFFF, 6'd53), 1'b0,
			'0});
		directed.push_back('{make_access(OP_READ, OFS_PUDCLK1, 32'h0, 6'd54), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUD, 32'h0000_0003, 6'd53), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUDCLK0, 32'h0000_0001, 6'd0), 1'b0,
			'0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUD, 32'h0000_0001, 6'd0), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUDCLK1, 32'h0, 6'd63), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUDCLK0, 32'h0, 6'd31), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, OFS_PUD, 32'h0, 6'd40), 1'b0, '0});
		directed.push_back('{make_access(OP_WRITE, 6'd3, 32'h1234_5678, 6'd32), 1'b0, '0});
		directed.push_back('{make_access(OP_READ, 6'd3, 32'h0, 6'd40), 1'b0, '0});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_access(directed[i].acc, directed[i].typed, directed[i].want);
		end
		drain_results();

		sent = 0;
		paused = 1'b0;
		while (sent < 1800) begin
			quiet = (sent >= 1600);
			if (!paused && sent >= 900) begin
				drain_results();
				paused = 1'b1;
			end
			case ($urandom_range(0, 5))
				0: d = '1;
				1: d = '0;
				2: d = 32'h1 << $urandom_range(0, 31);
				default: d = $urandom;
			endcase
			pr = ($urandom_range(0, 6) == 0) ? PIN_W'($urandom_range(0, 63))
				: PIN_W'($urandom_range(0, NUM_PINS - 1));
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// A full pull-up/down sequence: code, clock, read back, release, read the code.
				send_access(make_access(OP_WRITE, OFS_PUD, d, pr), 1'b0, '0);
				ofs = $urandom_range(0, 1) ? OFS_PUDCLK1 : OFS_PUDCLK0;
				send_access(make_access(OP_WRITE, ofs, $urandom, pr), 1'b0, '0);
				pr = PIN_W'($urandom_range(0, 63));
				send_access(make_access(OP_READ, ofs, $urandom, pr), 1'b0, '0);
				send_access(make_access(OP_WRITE, ofs, 32'h0, pr), 1'b0, '0);
				send_access(make_access(OP_READ, OFS_PUD, $urandom, pr), 1'b0, '0);
				sent += 5;
			end else begin
				if (pick < 45) begin
					ofs = OFS_W'($urandom_range(OFS_FSEL_FIRST, OFS_FSEL_LAST));
				end else if (pick < 75) begin
					case ($urandom_range(0, 3))
						0: ofs = OFS_SET0;
						1: ofs = OFS_SET1;
						2: ofs = OFS_CLR0;
						default: ofs = OFS_CLR1;
					endcase
				end else if (pick < 85) begin
					case ($urandom_range(0, 2))
						0: ofs = OFS_PUD;
						1: ofs = OFS_PUDCLK0;
						default: ofs = OFS_PUDCLK1;
					endcase
				end else begin
					ofs = OFS_W'($urandom_range(0, 63));
				end
				a = make_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, ofs, d, pr);
				send_access(a, 1'b0, '0);
				sent++;
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
